[rtl/text_case_transform_stream_top_assert.svh]
// Assertion macros for the text case transform result buffer
`ifndef TEXT_CASE_TRANSFORM_STREAM_TOP_ASSERT_SVH
`define TEXT_CASE_TRANSFORM_STREAM_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define TCT_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);
`define TCT_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TCT_ASSERT_IMP(lbl, ck, rn, ante, cons, msg)
`define TCT_ASSERT_NXT(lbl, ck, rn, ante, cons, msg)
`endif
`endif

[rtl/tct_pkg.sv]
// Types, constants and helper functions for the text case transform
`timescale 1ns / 1ps
`default_nettype none
package tct_pkg;

    localparam logic [3:0] MODE_NOBREAKS = 4'd0;
    localparam logic [3:0] MODE_UPPER    = 4'd1;
    localparam logic [3:0] MODE_LOWER    = 4'd2;
    localparam logic [3:0] MODE_TITLE    = 4'd3;
    localparam logic [3:0] MODE_SENTENCE = 4'd4;
    localparam logic [3:0] MODE_CAMEL    = 4'd5;
    localparam logic [3:0] MODE_INVERT   = 4'd6;
    localparam logic [3:0] MODE_ASCII    = 4'd7;
    localparam logic [3:0] MODE_SLUG     = 4'd8;
    localparam logic [3:0] MODE_PASS     = 4'd9;

    localparam logic [1:0] REG_MODE       = 2'd0;
    localparam logic [1:0] REG_SEP_LENGTH = 2'd1;
    localparam logic [1:0] REG_SEP_FIRST  = 2'd2;
    localparam logic [1:0] REG_SEP_SECOND = 2'd3;

    localparam logic [15:0] CH_HYPHEN = 16'h002D;
    localparam logic [15:0] CH_PERIOD = 16'h002E;
    localparam logic [15:0] CH_BANG   = 16'h0021;
    localparam logic [15:0] CH_QUERY  = 16'h003F;
    localparam logic [15:0] CH_LF     = 16'h000A;
    localparam logic [15:0] CH_CR     = 16'h000D;
    localparam logic [15:0] ASCII_END = 16'h0080;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        has_unit;
        logic        end_of_text;
    } in_item_t;

    typedef struct packed {
        logic [15:0] out_unit;
        logic        out_valid;
        logic        out_last;
    } out_item_t;

    typedef struct packed {
        logic [3:0]  mode;
        logic [1:0]  separator_length;
        logic [15:0] separator_first;
        logic [15:0] separator_second;
    } cfg_t;

    typedef struct packed {
        logic word_start;
        logic sentence_start;
        logic first_word;
        logic gap_pending;
        logic output_started;
    } flags_t;

    localparam flags_t FLAGS_RESET = '{
        word_start:     1'b1,
        sentence_start: 1'b1,
        first_word:     1'b1,
        gap_pending:    1'b0,
        output_started: 1'b0
    };

    // Up to three units per input transaction; a zero count leaves the result buffer empty
    typedef struct packed {
        logic [2:0][15:0] units;
        logic [1:0]       count;
        logic             bare;
        logic             last;
    } bundle_t;

    function automatic logic is_space(input logic [15:0] c);
        is_space = (c == 16'h0020) || (c == 16'h0009) || (c == 16'h000A) ||
                   (c == 16'h000B) || (c == 16'h000C) || (c == 16'h000D);
    endfunction

    function automatic logic is_upper(input logic [15:0] c);
        is_upper = (c >= 16'h0041) && (c <= 16'h005A);
    endfunction

    function automatic logic is_lower(input logic [15:0] c);
        is_lower = (c >= 16'h0061) && (c <= 16'h007A);
    endfunction

    function automatic logic is_digit(input logic [15:0] c);
        is_digit = (c >= 16'h0030) && (c <= 16'h0039);
    endfunction

    function automatic logic [15:0] to_upper(input logic [15:0] c);
        to_upper = is_lower(c) ? (c - 16'h0020) : c;
    endfunction

    function automatic logic [15:0] to_lower(input logic [15:0] c);
        to_lower = is_upper(c) ? (c + 16'h0020) : c;
    endfunction

endpackage
`default_nettype wire

[rtl/tct_cfg.sv]
// APB register file holding mode and slug separator settings
`timescale 1ns / 1ps
`default_nettype none
module tct_cfg (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [3:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output tct_pkg::cfg_t      cfg
);

    tct_pkg::cfg_t cfg_reg;
    logic          wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode             <= tct_pkg::MODE_PASS;
            cfg_reg.separator_length <= 2'd0;
            cfg_reg.separator_first  <= tct_pkg::CH_HYPHEN;
            cfg_reg.separator_second <= tct_pkg::CH_HYPHEN;
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                tct_pkg::REG_MODE:       cfg_reg.mode             <= pwdata[3:0];
                tct_pkg::REG_SEP_LENGTH: cfg_reg.separator_length <= pwdata[1:0];
                tct_pkg::REG_SEP_FIRST:  cfg_reg.separator_first  <= pwdata[15:0];
                tct_pkg::REG_SEP_SECOND: cfg_reg.separator_second <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            tct_pkg::REG_MODE:       prdata = {28'd0, cfg_reg.mode};
            tct_pkg::REG_SEP_LENGTH: prdata = {30'd0, cfg_reg.separator_length};
            tct_pkg::REG_SEP_FIRST:  prdata = {16'd0, cfg_reg.separator_first};
            tct_pkg::REG_SEP_SECOND: prdata = {16'd0, cfg_reg.separator_second};
            default:                 prdata = 32'd0;
        endcase
    end

endmodule
`default_nettype wire

[rtl/tct_xform.sv]
// Per-unit case transform with the word/sentence/gap flags
`timescale 1ns / 1ps
`default_nettype none
module tct_xform (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire tct_pkg::cfg_t    cfg,
    input  wire tct_pkg::in_item_t item,
    input  wire logic             load,
    output tct_pkg::bundle_t      bundle
);

    tct_pkg::flags_t  flags_reg;
    tct_pkg::flags_t  flags_next;
    tct_pkg::flags_t  flags_step;
    logic [15:0]      c;
    logic [15:0]      lc;
    logic [2:0][15:0] u;
    logic [1:0]       cnt;
    logic             is_alnum;

    always_comb
    begin
        c          = item.code_unit;
        lc         = tct_pkg::to_lower(c);
        is_alnum   = tct_pkg::is_upper(c) || tct_pkg::is_lower(c) || tct_pkg::is_digit(c);
        flags_step = flags_reg;
        u          = '0;
        cnt        = 2'd0;
        if (item.has_unit)
        begin
            case (cfg.mode)
                tct_pkg::MODE_NOBREAKS:
                begin
                    if (c != tct_pkg::CH_LF && c != tct_pkg::CH_CR)
                    begin
                        u[0] = c;
                        cnt  = 2'd1;
                    end
                end
                tct_pkg::MODE_UPPER:
                begin
                    u[0] = tct_pkg::to_upper(c);
                    cnt  = 2'd1;
                end
                tct_pkg::MODE_LOWER:
                begin
                    u[0] = lc;
                    cnt  = 2'd1;
                end
                tct_pkg::MODE_TITLE:
                begin
                    cnt = 2'd1;
                    if (tct_pkg::is_space(c))
                    begin
                        flags_step.word_start = 1'b1;
                        u[0] = c;
                    end
                    else if (flags_reg.word_start)
                    begin
                        flags_step.word_start = 1'b0;
                        u[0] = tct_pkg::to_upper(c);
                    end
                    else
                    begin
                        u[0] = lc;
                    end
                end
                tct_pkg::MODE_SENTENCE:
                begin
                    cnt = 2'd1;
                    if (c == tct_pkg::CH_PERIOD || c == tct_pkg::CH_BANG ||
                        c == tct_pkg::CH_QUERY)
                    begin
                        flags_step.sentence_start = 1'b1;
                        u[0] = c;
                    end
                    else if (tct_pkg::is_space(c))
                    begin
                        u[0] = c;
                    end
                    else if (flags_reg.sentence_start)
                    begin
                        flags_step.sentence_start = 1'b0;
                        u[0] = tct_pkg::to_upper(c);
                    end
                    else
                    begin
                        u[0] = lc;
                    end
                end
                tct_pkg::MODE_CAMEL:
                begin
                    if (is_alnum)
                    begin
                        cnt = 2'd1;
                        if (flags_reg.word_start)
                        begin
                            u[0] = flags_reg.first_word ? lc : tct_pkg::to_upper(c);
                            flags_step.first_word = 1'b0;
                            flags_step.word_start = 1'b0;
                        end
                        else
                        begin
                            u[0] = lc;
                        end
                    end
                    else
                    begin
                        flags_step.word_start = 1'b1;
                    end
                end
                tct_pkg::MODE_INVERT:
                begin
                    cnt = 2'd1;
                    if (tct_pkg::is_upper(c))
                        u[0] = lc;
                    else
                        u[0] = tct_pkg::to_upper(c);
                end
                tct_pkg::MODE_ASCII:
                begin
                    if (c < tct_pkg::ASCII_END)
                    begin
                        u[0] = c;
                        cnt  = 2'd1;
                    end
                end
                tct_pkg::MODE_SLUG:
                begin
                    if (tct_pkg::is_lower(lc) || tct_pkg::is_digit(lc))
                    begin
                        if (flags_reg.gap_pending && flags_reg.output_started)
                        begin
                            case (cfg.separator_length)
                                2'd0:
                                begin
                                    u[0] = tct_pkg::CH_HYPHEN;
                                    u[1] = lc;
                                    cnt  = 2'd2;
                                end
                                2'd1:
                                begin
                                    u[0] = cfg.separator_first;
                                    u[1] = lc;
                                    cnt  = 2'd2;
                                end
                                default:
                                begin
                                    // length three behaves as two
                                    u[0] = cfg.separator_first;
                                    u[1] = cfg.separator_second;
                                    u[2] = lc;
                                    cnt  = 2'd3;
                                end
                            endcase
                        end
                        else
                        begin
                            u[0] = lc;
                            cnt  = 2'd1;
                        end
                        flags_step.gap_pending    = 1'b0;
                        flags_step.output_started = 1'b1;
                    end
                    else if (flags_reg.output_started)
                    begin
                        flags_step.gap_pending = 1'b1;
                    end
                end
                default:
                begin
                    u[0] = c;
                    cnt  = 2'd1;
                end
            endcase
        end

        bundle.units = u;
        bundle.count = cnt;
        bundle.last  = item.end_of_text;
        bundle.bare  = 1'b0;
        // end of text with nothing emitted still yields one marker transaction
        if (item.end_of_text && cnt == 2'd0)
        begin
            bundle.bare  = 1'b1;
            bundle.count = 2'd1;
        end

        flags_next = item.end_of_text ? tct_pkg::FLAGS_RESET : flags_step;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            flags_reg <= tct_pkg::FLAGS_RESET;
        else if (load)
            flags_reg <= flags_next;
    end

endmodule
`default_nettype wire

[rtl/tct_outbuf.sv]
// Result register that hands out up to three units per input transaction
`timescale 1ns / 1ps
`default_nettype none
`include "text_case_transform_stream_top_assert.svh"
module tct_outbuf (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           load,
    input  wire tct_pkg::bundle_t bundle,
    output logic                free,
    output logic                res_valid,
    input  wire logic           res_stall,
    output tct_pkg::out_item_t  res_data
);

    tct_pkg::bundle_t bundle_reg;
    logic             full_reg;
    logic [1:0]       idx_reg;
    logic             pop;
    logic             final_unit;

    assign pop        = full_reg && !res_stall;
    assign final_unit = (idx_reg == (bundle_reg.count - 2'd1));
    assign free       = !full_reg || (pop && final_unit);

    assign res_valid          = full_reg;
    assign res_data.out_unit  = bundle_reg.bare ? 16'd0 : bundle_reg.units[idx_reg];
    assign res_data.out_valid = !bundle_reg.bare;
    assign res_data.out_last  = bundle_reg.last && final_unit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
            idx_reg  <= 2'd0;
        end
        else if (load)
        begin
            full_reg <= (bundle.count != 2'd0);
            idx_reg  <= 2'd0;
        end
        else if (pop)
        begin
            if (final_unit)
                full_reg <= 1'b0;
            else
                idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            bundle_reg <= bundle;
    end

    `TCT_ASSERT_IMP(a_idx_in_range, clk, rst_n, full_reg, idx_reg < bundle_reg.count,
        "result index past bundle count")
    `TCT_ASSERT_IMP(a_bare_single, clk, rst_n, full_reg && bundle_reg.bare,
        bundle_reg.count == 2'd1 && bundle_reg.last,
        "bare end marker not a single last transaction")
    `TCT_ASSERT_IMP(a_load_when_free, clk, rst_n, load, free,
        "bundle loaded over pending results")
    `TCT_ASSERT_NXT(a_idx_hold, clk, rst_n, full_reg && res_stall && !load,
        full_reg && $stable(idx_reg), "result index moved under stall")

endmodule
`default_nettype wire

[rtl/text_case_transform_stream_top.sv]
// Top level of the streaming text case transform
//
//  channel  direction  handshake              payload
//  in       input      in_valid / in_stall    in_data  (code_unit, has_unit, end_of_text)
//  res      output     res_valid / res_stall  res_data (out_unit, out_valid, out_last)
//  cfg      APB        psel/penable/pready    paddr, pwdata, prdata
//
// One input transaction per cycle while res_stall stays low; a transaction yielding
// two or three units (slug separator) holds the input side until its last unit is out.
// Data passes the input register, then the transform into the result register.
// Reset clears valids and sets the text flags to their start values; registers return to mode pass-through.
// in_stall rises only while the input register is full and the result register
// still has units to hand out.
`timescale 1ns / 1ps
`default_nettype none
module text_case_transform_stream_top (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_stall,
    input  wire tct_pkg::in_item_t in_data,
    output logic                res_valid,
    input  wire logic           res_stall,
    output tct_pkg::out_item_t  res_data,
    input  wire logic           psel,
    input  wire logic           penable,
    input  wire logic           pwrite,
    input  wire logic [3:0]     paddr,
    input  wire logic [31:0]    pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    tct_pkg::cfg_t     cfg;
    tct_pkg::in_item_t item_reg;
    tct_pkg::bundle_t  bundle;
    logic              item_valid_reg;
    logic              item_valid_next;
    logic              buf_free;
    logic              advance;
    logic              in_take;

    assign advance  = item_valid_reg && buf_free;
    assign in_stall = item_valid_reg && !buf_free;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (in_take)
            item_valid_next = 1'b1;
        else if (advance)
            item_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else
            item_valid_reg <= item_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            item_reg <= in_data;
    end

    tct_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tct_xform u_xform (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .item   (item_reg),
        .load   (advance),
        .bundle (bundle)
    );

    tct_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance),
        .bundle    (bundle),
        .free      (buf_free),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

endmodule
`default_nettype wire
